// ===== rtl/pnps_pkg.sv =====
// Shared constants, types and command/result formats of the packed nibble pixel store.
`default_nettype none
package pnps_pkg;

	// Surface geometry
	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 64;
	localparam int MAX_READ    = 64;
	localparam int ROW_BYTES   = (MAX_WIDTH + 1) / 2;
	localparam int STORE_DEPTH = ROW_BYTES * MAX_HEIGHT;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int BCOL_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CNT_W       = $clog2(MAX_READ + 1);
	localparam int COL_W       = 11;

	// Register field widths
	localparam int WIDTH_W = 8;
	localparam int HEIGHT_W = 7;
	localparam int CODE_W  = 8;

	// Queues
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = 1;
	localparam int QCNT_W    = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OPTR_W    = 2;
	localparam int OCNT_W    = 3;

	// Nibble codes
	localparam logic [3:0] NIB_CLEAR = 4'hF;
	localparam logic [3:0] NIB_TOP   = 4'd14;

	typedef enum logic [2:0] {
		OP_SET       = 3'd0,
		OP_GET       = 3'd1,
		OP_FILL_SPAN = 3'd2,
		OP_READ_SPAN = 3'd3,
		OP_TEST_SPAN = 3'd4,
		OP_CLEAR     = 3'd5,
		OP_FILL_ALL  = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		REG_SURFACE_WIDTH  = 2'd0,
		REG_SURFACE_HEIGHT = 2'd1,
		REG_TRANSP_CODE    = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_FILL = 2'd0,
		KIND_READ = 2'd1,
		KIND_TEST = 2'd2
	} cmd_kind_t;

	typedef logic signed [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0]        row_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	// Effective geometry and transparent code; the user must hold them stable while busy, the block does not enforce it
	typedef struct packed {
		logic [WIDTH_W-1:0]  eff_w;
		logic [HEIGHT_W-1:0] eff_h;
		logic [CODE_W-1:0]   tcode;
	} geom_t;

	// Classified command passed from front to back
	typedef struct packed {
		cmd_kind_t  kind;
		logic       empty;
		logic       row_ok;
		col_t       lo;
		col_t       hi;
		row_t       row_lo;
		row_t       row_hi;
		cnt_t       count;
		logic [3:0] nib;
		logic       clamp;
	} cmd_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       all_clear;
		logic       clamp_seen;
		logic       last_result;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/packed_nibble_pixel_store_core.sv =====
// Top level: configuration registers, front end, back end with the pixel store.
// A result passes through the front-end queue, the command register, the stage 1 register and
// the result queue. The back end takes a new command only from idle: a span fill steps over
// each byte the clipped span touches, a read span over each pixel, a span test over each
// clipped pixel (at least one), clear and fill all over every byte of every row. Result steps
// wait for room in the result queue. Reset: a clearing pass of all 4096 addresses sets every
// pixel transparent; no command is taken meanwhile, configuration writes are always taken.
`default_nettype none
module packed_nibble_pixel_store_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata, // pos_x[8:0], pos_y[16:9], span_length[24:17], pixel_value[32:25]
	input  wire logic [2:0]  s_tuser,   // opcode[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // pixel_out[7:0], all_clear[8], clamp_seen[9]
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic [pnps_pkg::WIDTH_W-1:0]  surface_width_q;
	logic [pnps_pkg::HEIGHT_W-1:0] surface_height_q;
	logic [pnps_pkg::CODE_W-1:0]   transparent_code_q;
	pnps_pkg::geom_t               geom;
	logic                          init_done;
	logic                          cmd_valid, cmd_ready;
	pnps_pkg::cmd_t                cmd;

	assign cfg_ready = 1'b1;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_width_q    <= 8'd128;
			surface_height_q   <= 7'd64;
			transparent_code_q <= 8'd253;
		end else if (cfg_valid && cfg_ready) begin
			case (pnps_pkg::cfg_reg_t'(cfg_index))
				pnps_pkg::REG_SURFACE_WIDTH:  surface_width_q    <= cfg_data;
				pnps_pkg::REG_SURFACE_HEIGHT: surface_height_q   <= cfg_data[6:0];
				pnps_pkg::REG_TRANSP_CODE:    transparent_code_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Limit the geometry to the store size
	always_comb begin
		geom.eff_w = (32'(surface_width_q) > pnps_pkg::MAX_WIDTH) ?
			pnps_pkg::WIDTH_W'(pnps_pkg::MAX_WIDTH) : surface_width_q;
		geom.eff_h = (32'(surface_height_q) > pnps_pkg::MAX_HEIGHT) ?
			pnps_pkg::HEIGHT_W'(pnps_pkg::MAX_HEIGHT) : surface_height_q;
		geom.tcode = transparent_code_q;
	end

	pnps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.geom      (geom),
		.init_done (init_done),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	pnps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.init_done (init_done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/pnps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pnps_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/pnps_front.sv =====
// Front end: accepts commands, encodes the colour, clips spans and queues work for the back end.
`default_nettype none
module pnps_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [39:0]    s_tdata,
	input  wire logic [2:0]     s_tuser,
	input  wire pnps_pkg::geom_t geom,
	input  wire logic           init_done,
	output logic                cmd_valid,
	input  wire logic           cmd_ready,
	output pnps_pkg::cmd_t      cmd
);

	logic signed [8:0] pos_x;
	logic signed [7:0] pos_y;
	logic [7:0]        span_length;
	logic [7:0]        pixel_value;

	pnps_pkg::cmd_t    cls;
	logic              keep;
	pnps_pkg::col_t    xs, ys, len_s, ew_s, eh_s, end_s, lo_c, hi_c;
	logic              row_ok, in_surf, span_ok, all_empty;
	logic [3:0]        nib_e;
	logic              clamp_e;

	pnps_pkg::cmd_t    q_mem_q [pnps_pkg::QDEPTH];
	logic [pnps_pkg::QPTR_W-1:0] q_wr_q, q_rd_q;
	logic [pnps_pkg::QCNT_W-1:0] q_cnt_q;
	logic              accept, push, pop;

	// Unpack the transaction fields
	assign pos_x       = s_tdata[8:0];
	assign pos_y       = s_tdata[16:9];
	assign span_length = s_tdata[24:17];
	assign pixel_value = s_tdata[32:25];

	// Encode the colour into a nibble
	always_comb begin
		if (pixel_value == geom.tcode) begin
			nib_e   = pnps_pkg::NIB_CLEAR;
			clamp_e = 1'b0;
		end else if (pixel_value <= {4'd0, pnps_pkg::NIB_TOP}) begin
			nib_e   = pixel_value[3:0];
			clamp_e = 1'b0;
		end else begin
			nib_e   = pnps_pkg::NIB_TOP;
			clamp_e = 1'b1;
		end
	end

	// Work out geometry checks and clipped column ranges
	always_comb begin
		xs        = pnps_pkg::COL_W'(pos_x);
		ys        = pnps_pkg::COL_W'(pos_y);
		len_s     = pnps_pkg::COL_W'(span_length);
		ew_s      = pnps_pkg::COL_W'(geom.eff_w);
		eh_s      = pnps_pkg::COL_W'(geom.eff_h);
		end_s     = xs + len_s;
		row_ok    = (ys >= pnps_pkg::col_t'(0)) && (ys < eh_s);
		in_surf   = row_ok && (xs >= pnps_pkg::col_t'(0)) && (xs < ew_s);
		lo_c      = (xs < pnps_pkg::col_t'(0)) ? pnps_pkg::col_t'(0) : xs;
		hi_c      = (end_s > ew_s) ? ew_s : end_s;
		span_ok   = row_ok && (hi_c > lo_c);
		all_empty = (geom.eff_w == '0) || (geom.eff_h == '0);
	end

	// Classify the command
	always_comb begin
		cls        = '0;
		cls.kind   = pnps_pkg::KIND_FILL;
		cls.empty  = 1'b1;
		cls.row_ok = row_ok;
		cls.row_lo = ys[pnps_pkg::ROW_W-1:0];
		cls.row_hi = ys[pnps_pkg::ROW_W-1:0];
		cls.nib    = nib_e;
		keep       = 1'b1;
		case (pnps_pkg::op_t'(s_tuser))
			pnps_pkg::OP_SET: begin
				cls.empty = !in_surf;
				cls.lo    = xs;
				cls.hi    = xs + pnps_pkg::col_t'(1);
				cls.clamp = clamp_e && in_surf;
			end
			pnps_pkg::OP_GET: begin
				cls.kind  = pnps_pkg::KIND_READ;
				cls.empty = 1'b0;
				cls.lo    = xs;
				cls.count = pnps_pkg::CNT_W'(1);
			end
			pnps_pkg::OP_FILL_SPAN: begin
				cls.empty = !span_ok;
				cls.lo    = lo_c;
				cls.hi    = hi_c;
				cls.clamp = clamp_e && span_ok;
			end
			pnps_pkg::OP_READ_SPAN: begin
				keep      = (span_length != '0);
				cls.kind  = pnps_pkg::KIND_READ;
				cls.empty = 1'b0;
				cls.lo    = xs;
				cls.count = (32'(span_length) > pnps_pkg::MAX_READ) ?
					pnps_pkg::CNT_W'(pnps_pkg::MAX_READ) : pnps_pkg::CNT_W'(span_length);
			end
			pnps_pkg::OP_TEST_SPAN: begin
				cls.kind  = pnps_pkg::KIND_TEST;
				cls.empty = !span_ok;
				cls.lo    = lo_c;
				cls.hi    = hi_c;
			end
			pnps_pkg::OP_CLEAR: begin
				cls.empty  = all_empty;
				cls.lo     = pnps_pkg::col_t'(0);
				cls.hi     = ew_s;
				cls.row_lo = '0;
				cls.row_hi = pnps_pkg::ROW_W'(geom.eff_h - pnps_pkg::HEIGHT_W'(1));
				cls.nib    = pnps_pkg::NIB_CLEAR;
			end
			pnps_pkg::OP_FILL_ALL: begin
				cls.empty  = all_empty;
				cls.lo     = pnps_pkg::col_t'(0);
				cls.hi     = ew_s;
				cls.row_lo = '0;
				cls.row_hi = pnps_pkg::ROW_W'(geom.eff_h - pnps_pkg::HEIGHT_W'(1));
				cls.clamp  = clamp_e && !all_empty;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Handshake and queue control
	assign s_tready  = init_done && (q_cnt_q != pnps_pkg::QCNT_W'(pnps_pkg::QDEPTH));
	assign accept    = s_tvalid && s_tready;
	assign push      = accept && keep;
	assign cmd_valid = (q_cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[q_rd_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[q_wr_q] <= cls;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (push) begin
				q_wr_q <= (32'(q_wr_q) == pnps_pkg::QDEPTH - 1) ? '0 :
					q_wr_q + pnps_pkg::QPTR_W'(1);
			end
			if (pop) begin
				q_rd_q <= (32'(q_rd_q) == pnps_pkg::QDEPTH - 1) ? '0 :
					q_rd_q + pnps_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				q_cnt_q <= q_cnt_q + pnps_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				q_cnt_q <= q_cnt_q - pnps_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/pnps_back.sv =====
// Back end: sequences store sweeps, span reads and tests, and queues the results.
`default_nettype none
module pnps_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pnps_pkg::geom_t geom,
	input  wire logic            cmd_valid,
	output logic                 cmd_ready,
	input  wire pnps_pkg::cmd_t  cmd,
	output logic                 init_done,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [15:0]          m_tdata,
	output logic                 m_tlast
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_TEST
	} state_t;

	state_t                        state_q;
	pnps_pkg::cmd_t                cur_q;
	pnps_pkg::col_t                col_q;
	pnps_pkg::row_t                row_q;
	pnps_pkg::cnt_t                cnt_q;
	logic [pnps_pkg::ADDR_W-1:0]   init_q;
	logic                          clamp_q;

	pnps_pkg::col_t                lo_s, hi_s, ew_s, col_p1, col_p2, lo_even, cmd_lo;
	logic                          fill_last, last_col, read_last, test_last, rd_inside;
	logic                          credit_ok, step, last_step, emit, step_inside;
	logic [pnps_pkg::BCOL_W-1:0]   bcol;
	logic [pnps_pkg::ADDR_W-1:0]   addr, waddr;
	logic                          we_e, we_o, fill_we_e, fill_we_o;
	logic [3:0]                    wdata;
	logic [3:0]                    rd_even, rd_odd;

	logic                          valid_s1;
	pnps_pkg::cmd_kind_t           kind_s1;
	logic                          emit_s1, inside_s1, odd_s1, last_s1;
	logic                          acc_q, acc_next, hit;
	logic [3:0]                    nib;
	pnps_pkg::result_t             res;

	pnps_pkg::result_t             res_mem_q [pnps_pkg::OUT_DEPTH];
	logic [pnps_pkg::OPTR_W-1:0]   res_wr_q, res_rd_q;
	logic [pnps_pkg::OCNT_W-1:0]   res_cnt_q;
	logic                          res_push, res_pop;
	pnps_pkg::result_t             res_head;

	// Column arithmetic for the current step
	always_comb begin
		lo_s      = cur_q.lo;
		hi_s      = cur_q.hi;
		cmd_lo    = cmd.lo;
		ew_s      = pnps_pkg::COL_W'(geom.eff_w);
		col_p1    = col_q + pnps_pkg::col_t'(1);
		col_p2    = col_q + pnps_pkg::col_t'(2);
		lo_even   = {lo_s[pnps_pkg::COL_W-1:1], 1'b0};
		last_col  = (col_p2 >= hi_s);
		fill_last = cur_q.empty || (last_col && (row_q == cur_q.row_hi));
		fill_we_e = !cur_q.empty && (col_q >= lo_s) && (col_q < hi_s);
		fill_we_o = !cur_q.empty && (col_p1 >= lo_s) && (col_p1 < hi_s);
		read_last = (cnt_q == pnps_pkg::CNT_W'(1));
		rd_inside = cur_q.row_ok && (col_q >= pnps_pkg::col_t'(0)) && (col_q < ew_s);
		test_last = cur_q.empty || (col_p1 >= hi_s);
		credit_ok = (int'(res_cnt_q) + int'(valid_s1 && emit_s1)) < pnps_pkg::OUT_DEPTH;
	end

	// Decide whether a step goes ahead this cycle
	always_comb begin
		step        = 1'b0;
		last_step   = 1'b0;
		emit        = 1'b0;
		step_inside = 1'b0;
		case (state_q)
			ST_FILL: begin
				step      = !fill_last || credit_ok;
				last_step = fill_last;
				emit      = fill_last;
			end
			ST_READ: begin
				step        = credit_ok;
				last_step   = read_last;
				emit        = 1'b1;
				step_inside = rd_inside;
			end
			ST_TEST: begin
				step        = !test_last || credit_ok;
				last_step   = test_last;
				emit        = test_last;
				step_inside = !cur_q.empty;
			end
			default: begin
				step = 1'b0;
			end
		endcase
	end

	// Store addressing and write enables
	always_comb begin
		bcol = col_q[pnps_pkg::BCOL_W:1];
		addr = pnps_pkg::ADDR_W'(32'(row_q) * pnps_pkg::ROW_BYTES + 32'(bcol));
		if (state_q == ST_INIT) begin
			waddr = init_q;
			we_e  = 1'b1;
			we_o  = 1'b1;
			wdata = pnps_pkg::NIB_CLEAR;
		end else begin
			waddr = addr;
			we_e  = (state_q == ST_FILL) && step && fill_we_e;
			we_o  = (state_q == ST_FILL) && step && fill_we_o;
			wdata = cur_q.nib;
		end
	end

	pnps_ram #(
		.WIDTH (4),
		.DEPTH (pnps_pkg::STORE_DEPTH)
	) u_ram_even (
		.clk   (clk),
		.we    (we_e),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rd_even)
	);

	pnps_ram #(
		.WIDTH (4),
		.DEPTH (pnps_pkg::STORE_DEPTH)
	) u_ram_odd (
		.clk   (clk),
		.we    (we_o),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rd_odd)
	);

	assign cmd_ready = (state_q == ST_IDLE);
	assign init_done = (state_q != ST_INIT);

	// Sequencer: clearing pass, command take-up and sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q  <= '0;
			clamp_q <= 1'b0;
			cur_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + pnps_pkg::ADDR_W'(1);
					if (32'(init_q) == pnps_pkg::STORE_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						row_q   <= cmd.row_lo;
						cnt_q   <= cmd.count;
						clamp_q <= clamp_q | cmd.clamp;
						case (cmd.kind)
							pnps_pkg::KIND_FILL: begin
								col_q   <= {cmd_lo[pnps_pkg::COL_W-1:1], 1'b0};
								state_q <= ST_FILL;
							end
							pnps_pkg::KIND_READ: begin
								col_q   <= cmd_lo;
								state_q <= ST_READ;
							end
							default: begin
								col_q   <= cmd_lo;
								state_q <= ST_TEST;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (step) begin
						if (fill_last) begin
							state_q <= ST_IDLE;
						end else if (last_col) begin
							col_q <= lo_even;
							row_q <= row_q + pnps_pkg::ROW_W'(1);
						end else begin
							col_q <= col_p2;
						end
					end
				end
				ST_READ: begin
					if (step) begin
						col_q <= col_p1;
						cnt_q <= cnt_q - pnps_pkg::CNT_W'(1);
						if (read_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TEST: begin
					if (step) begin
						col_q <= col_p1;
						if (test_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Stage 1: carry step info alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			kind_s1   <= pnps_pkg::KIND_FILL;
			emit_s1   <= 1'b0;
			inside_s1 <= 1'b0;
			odd_s1    <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			valid_s1  <= step;
			kind_s1   <= cur_q.kind;
			emit_s1   <= emit;
			inside_s1 <= step_inside;
			odd_s1    <= col_q[0];
			last_s1   <= last_step;
		end
	end

	// Decode the nibble and build the result
	always_comb begin
		nib      = odd_s1 ? rd_odd : rd_even;
		hit      = inside_s1 && (nib != pnps_pkg::NIB_CLEAR);
		acc_next = acc_q && !hit;
		res      = '0;
		if (kind_s1 == pnps_pkg::KIND_READ) begin
			res.pixel_out = hit ? {4'd0, nib} : geom.tcode;
		end
		if (kind_s1 == pnps_pkg::KIND_TEST) begin
			res.all_clear = acc_next;
		end
		res.clamp_seen  = clamp_q;
		res.last_result = last_s1;
		res_push        = valid_s1 && emit_s1;
	end

	// Accumulate the span transparency answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b1;
		end else if (valid_s1 && (kind_s1 == pnps_pkg::KIND_TEST)) begin
			acc_q <= last_s1 ? 1'b1 : acc_next;
		end
	end

	// Result queue towards the master side
	assign res_head = res_mem_q[res_rd_q];
	assign m_tvalid = (res_cnt_q != '0);
	assign res_pop  = m_tvalid && m_tready;
	assign m_tdata  = {6'd0, res_head.clamp_seen, res_head.all_clear, res_head.pixel_out};
	assign m_tlast  = res_head.last_result;

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= (32'(res_wr_q) == pnps_pkg::OUT_DEPTH - 1) ? '0 :
					res_wr_q + pnps_pkg::OPTR_W'(1);
			end
			if (res_pop) begin
				res_rd_q <= (32'(res_rd_q) == pnps_pkg::OUT_DEPTH - 1) ? '0 :
					res_rd_q + pnps_pkg::OPTR_W'(1);
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + pnps_pkg::OCNT_W'(1);
			end else if (res_pop && !res_push) begin
				res_cnt_q <= res_cnt_q - pnps_pkg::OCNT_W'(1);
			end
		end
	end

	// The credit check must keep the result queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res_pop) |-> (res_cnt_q < pnps_pkg::OCNT_W'(pnps_pkg::OUT_DEPTH)))
		else $error("result queue overflow");

	// A span read in progress always has pixels left to produce
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (cnt_q != '0))
		else $error("span read running with zero count");

	// The transparency accumulator re-arms after each test result
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && (kind_s1 == pnps_pkg::KIND_TEST)) |=> acc_q)
		else $error("test accumulator not re-armed");

	// Store writes only happen in the clearing pass or a fill sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		(we_e || we_o) |-> ((state_q == ST_INIT) || (state_q == ST_FILL)))
		else $error("store write outside a fill");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the packed nibble pixel store: directed probes, then random traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import pnps_pkg::*;

	// Opcode with no meaning: the block must drop it without a result
	localparam logic [2:0] OP_NONE = 3'd7;
	localparam int STALL_LIMIT = 20000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 39;
	localparam int N_PHASES = 8;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;  // pos_x[8:0], pos_y[16:9], span_length[24:17], pixel_value[32:25]
	logic [2:0] s_tuser = '0;   // opcode[2:0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;       // pixel_out[7:0], all_clear[8], clamp_seen[9]
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	packed_nibble_pixel_store_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mirror of the store, one nibble per pixel, plus registers and sticky flag
	logic [3:0] pix_nib [MAX_HEIGHT][MAX_WIDTH];
	logic clamp_sticky;
	int surf_w, surf_h, transp;

	result_t pending_results [$];
	int mismatch_cnt = 0;
	int stall_cycles = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit rx_hold_req = 1'b0;

	function automatic int eff_w();
		return (surf_w > MAX_WIDTH) ? MAX_WIDTH : surf_w;
	endfunction

	function automatic int eff_h();
		return (surf_h > MAX_HEIGHT) ? MAX_HEIGHT : surf_h;
	endfunction

	function automatic bit on_surface(int x, int y);
		return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
	endfunction

	// Encode an eight-bit colour to a nibble; clamping raises the sticky flag
	function automatic logic [3:0] encode_value(int v);
		if (v == transp) return NIB_CLEAR;
		if (v <= 14) return v[3:0];
		clamp_sticky = 1'b1;
		return NIB_TOP;
	endfunction

	function automatic logic [7:0] decode_at(int x, int y);
		if (!on_surface(x, y)) return transp[7:0];
		if (pix_nib[y][x] == NIB_CLEAR) return transp[7:0];
		return {4'd0, pix_nib[y][x]};
	endfunction

	function automatic void push_result(logic [7:0] px, logic clr, logic last);
		result_t r;
		r.pixel_out = px;
		r.all_clear = clr;
		r.clamp_seen = clamp_sticky;
		r.last_result = last;
		pending_results.push_back(r);
	endfunction

	function automatic void paint_surface(logic [3:0] nib);
		for (int yy = 0; yy < eff_h(); yy++)
			for (int xx = 0; xx < eff_w(); xx++)
				pix_nib[yy][xx] = nib;
	endfunction

	// Apply one command to the mirror and queue the results it must produce
	function automatic void model_command(logic [2:0] op, logic [8:0] rx, logic [7:0] ry,
			logic [7:0] len, logic [7:0] val);
		int x, y, ln, v, n, a, b;
		logic [3:0] nib;
		bit clr;
		x = $signed(rx);
		y = $signed(ry);
		ln = len;
		v = val;
		case (op)
			OP_SET: begin
				if (on_surface(x, y)) pix_nib[y][x] = encode_value(v);
				push_result(8'd0, 1'b0, 1'b1);
			end
			OP_GET: push_result(decode_at(x, y), 1'b0, 1'b1);
			OP_FILL_SPAN: begin
				if (y >= 0 && y < eff_h()) begin
					a = (x < 0) ? 0 : x;
					b = x + ln;
					if (b > eff_w()) b = eff_w();
					if (b > a) begin
						nib = encode_value(v);
						for (int i = a; i < b; i++) pix_nib[y][i] = nib;
					end
				end
				push_result(8'd0, 1'b0, 1'b1);
			end
			OP_READ_SPAN: begin
				n = (ln > MAX_READ) ? MAX_READ : ln;
				for (int i = 0; i < n; i++) push_result(decode_at(x + i, y), 1'b0, i == n - 1);
			end
			OP_TEST_SPAN: begin
				clr = 1'b1;
				for (int i = 0; i < ln; i++)
					if (on_surface(x + i, y) && pix_nib[y][x + i] != NIB_CLEAR) clr = 1'b0;
				push_result(8'd0, clr, 1'b1);
			end
			OP_CLEAR: begin
				paint_surface(NIB_CLEAR);
				push_result(8'd0, 1'b0, 1'b1);
			end
			OP_FILL_ALL: begin
				if (eff_w() > 0 && eff_h() > 0) paint_surface(encode_value(v));
				push_result(8'd0, 1'b0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// Offer one command after a random gap; predict once the transaction completes
	task automatic send_cmd(logic [2:0] op, logic [8:0] rx, logic [7:0] ry,
			logic [7:0] len, logic [7:0] val);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, val, len, ry, rx};
		do @(posedge clk); while (!s_tready);
		model_command(op, rx, ry, len, val);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SURFACE_WIDTH: surf_w = data;
			REG_SURFACE_HEIGHT: surf_h = data[6:0];
			REG_TRANSP_CODE: transp = data;
			default: ;
		endcase
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every outstanding result, then let the back end settle
	task automatic drain_and_settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Mostly well-formed commands near the surface, some raw noise
	task automatic random_command();
		int r, op, x, y, ln, v, ew, eh;
		ew = eff_w();
		eh = eff_h();
		if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
		if ($urandom_range(0, 99) < 15) begin
			op = $urandom_range(0, 7);
			if ((op == OP_CLEAR || op == OP_FILL_ALL) && $urandom_range(0, 3) != 0) op = OP_GET;
			x = $urandom_range(0, 511);
			y = $urandom_range(0, 255);
			ln = $urandom_range(0, 255);
			v = $urandom_range(0, 255);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 28) op = OP_SET;
			else if (r < 52) op = OP_GET;
			else if (r < 64) op = OP_FILL_SPAN;
			else if (r < 76) op = OP_READ_SPAN;
			else if (r < 88) op = OP_TEST_SPAN;
			else if (r < 90) op = OP_CLEAR;
			else if (r < 92) op = OP_FILL_ALL;
			else if (r < 94) op = OP_NONE;
			else op = OP_SET;
			x = int'($urandom_range(0, ew + 2)) - 1;
			y = int'($urandom_range(0, eh + 1)) - 1;
			if ((op == OP_FILL_SPAN || op == OP_TEST_SPAN || op == OP_READ_SPAN)
					&& $urandom_range(0, 3) == 0)
				x = x - int'($urandom_range(0, 20));
			ln = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
			r = $urandom_range(0, 9);
			if (r < 4) v = $urandom_range(0, 14);
			else if (r < 6) v = transp;
			else v = $urandom_range(0, 255);
		end
		send_cmd(op[2:0], x[8:0], y[7:0], ln[7:0], v[7:0]);
	endtask

	// Directed probes; typed rows carry a result that is plain from the spec
	typedef struct packed {
		logic [2:0] op;
		int x;
		int y;
		int len;
		int val;
		int typed;
		int px;
		int clr;
		int clamp;
	} probe_row_t;

	localparam int N_PROBES = 26;
	probe_row_t probes [N_PROBES] = '{
		'{OP_GET,          0,    0,   0,   0, 1, 253, 0, 0},  // fresh store is transparent
		'{OP_TEST_SPAN,    0,    0, 255,   0, 1,   0, 1, 0},
		'{OP_GET,       -256, -128,   0,   0, 1, 253, 0, 0},  // most negative corner
		'{OP_GET,        255,  127,   0,   0, 1, 253, 0, 0},  // far outside
		'{OP_SET,        127,   63,   0,  14, 1,   0, 0, 0},  // last pixel, top nibble value
		'{OP_GET,        127,   63,   0,   0, 1,  14, 0, 0},
		'{OP_SET,          0,    0,   0,   0, 0,   0, 0, 0},
		'{OP_GET,          0,    0,   0,   0, 1,   0, 0, 0},
		'{OP_SET,          1,    0,   0, 253, 0,   0, 0, 0},  // transparent code on odd column
		'{OP_GET,          1,    0,   0,   0, 1, 253, 0, 0},
		'{OP_SET,          2,    0,   0, 255, 1,   0, 0, 1},  // clamps and raises the flag
		'{OP_GET,          2,    0,   0,   0, 1,  14, 0, 1},
		'{OP_SET,        128,    0,   0, 200, 0,   0, 0, 0},  // outside: ignored
		'{OP_FILL_SPAN,   -5,    1,  20,   7, 0,   0, 0, 0},  // clipped at the left edge
		'{OP_READ_SPAN,   -3,    1,  10,   0, 0,   0, 0, 0},
		'{OP_READ_SPAN,    0,    1,   0,   0, 0,   0, 0, 0},  // zero length: no result
		'{OP_READ_SPAN,  100,    2, 255,   0, 0,   0, 0, 0},  // capped read, runs off the row
		'{OP_TEST_SPAN,    0,    1,   4,   0, 1,   0, 0, 1},
		'{OP_TEST_SPAN, -256,    1, 100,   0, 1,   0, 1, 1},  // wholly outside answers clear
		'{OP_FILL_SPAN,    0,   64, 255,   3, 0,   0, 0, 0},  // row outside
		'{OP_FILL_SPAN,  120,    5, 255,   3, 0,   0, 0, 0},  // clipped at the right edge
		'{OP_NONE,         0,    0,   0,   0, 0,   0, 0, 0},
		'{OP_CLEAR,        0,    0,   0,   0, 0,   0, 0, 0},
		'{OP_TEST_SPAN,    0,    1, 255,   0, 1,   0, 1, 1},
		'{OP_FILL_ALL,     0,    0,   0,   9, 0,   0, 0, 0},
		'{OP_GET,          5,    5,   0,   0, 1,   9, 0, 1}
	};

	// Register settings per phase: width, height, transparent code
	int phase_cfg [N_PHASES][3] = '{
		'{128, 64, 253}, '{0, 64, 7}, '{255, 127, 0}, '{1, 1, 255},
		'{9, 3, 14}, '{0, 0, 0}, '{128, 0, 100}, '{50, 64, 15}
	};

	// Stimulus and end of run
	initial begin
		int w, h, tc;
		result_t typed_res;
		for (int yy = 0; yy < MAX_HEIGHT; yy++)
			for (int xx = 0; xx < MAX_WIDTH; xx++)
				pix_nib[yy][xx] = NIB_CLEAR;
		clamp_sticky = 1'b0;
		surf_w = 128;
		surf_h = 64;
		transp = 253;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (probes[i]) begin
			send_cmd(probes[i].op, probes[i].x[8:0], probes[i].y[7:0], probes[i].len[7:0],
				probes[i].val[7:0]);
			if (probes[i].typed != 0) begin
				typed_res.pixel_out = probes[i].px[7:0];
				typed_res.all_clear = probes[i].clr[0];
				typed_res.clamp_seen = probes[i].clamp[0];
				typed_res.last_result = 1'b1;
				pending_results[pending_results.size() - 1] = typed_res;
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_and_settle();
			w = phase_cfg[ph][0];
			h = phase_cfg[ph][1];
			tc = phase_cfg[ph][2];
			if (ph == 5) begin
				w = $urandom_range(0, 255);
				h = $urandom_range(0, 127);
				tc = $urandom_range(0, 255);
			end
			write_reg(REG_TRANSP_CODE, tc[7:0]);
			write_reg(REG_SURFACE_WIDTH, w[7:0]);
			write_reg(REG_SURFACE_HEIGHT, h[7:0]);
			// Back-pressure: hold the receiver off while offering back-to-back gets
			if (ph == 0) begin
				rx_hold_req = 1'b1;
				tx_burst = 1'b1;
				for (int k = 0; k < 24; k++) send_cmd(OP_GET, k[8:0], 8'd0, 8'd0, 8'd0);
				tx_burst = 1'b0;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 4 && k == 20) drain_and_settle();
				random_command();
			end
		end

		drain_and_settle();
		repeat (16) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Receiver: random stall before each result, one long hold on request
	initial begin
		int wait_n;
		forever begin
			if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
			wait_n = rx_burst ? 0 : $urandom_range(0, 17);
			if (rx_hold_req) begin
				wait_n = RX_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (wait_n > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (wait_n - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_tvalid));
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.pixel_out = m_tdata[7:0];
			got.all_clear = m_tdata[8];
			got.clamp_seen = m_tdata[9];
			got.last_result = m_tlast;
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result: pixel %0d clear %0d clamp %0d last %0d",
						got.pixel_out, got.all_clear, got.clamp_seen, got.last_result);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("result differs: want pixel %0d clear %0d clamp %0d last %0d,",
							want.pixel_out, want.all_clear, want.clamp_seen, want.last_result,
							" got pixel %0d clear %0d clamp %0d last %0d",
							got.pixel_out, got.all_clear, got.clamp_seen, got.last_result);
				end
			end
		end
	end

	// Watchdog: abort when no transaction of any kind completes for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
`default_nettype wire
